[design/fqd_pkg.sv]
// shared types, codes and sizes for the fifo queue with delete by tag
package fqd_pkg;

   localparam int DEPTH     = 16;
   localparam int TAG_WIDTH = 32;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [1:0] CMD_DELETE  = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NULL    = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_MISSING = 3'd4;

   typedef struct packed {
      logic [1:0]           command;
      logic [TAG_WIDTH-1:0] tag_in;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [TAG_WIDTH-1:0] tag_out;
      logic [CNT_WIDTH-1:0] length;
   } rsp_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                 match_en;
      logic                 shift_en;
      logic [TAG_WIDTH-1:0] key;
   } cell_ctl_type;

endpackage

[design/fqd_cell.sv]
// one queue cell: holds one tag, compares it to the key and shifts down on removal
module fqd_cell (
   input  logic                        clock,
   input  fqd_pkg::cell_ctl_type       ctl,
   input  logic                        live,
   input  logic                        load,
   input  logic                        seed_in,
   output logic                        seed_out,
   input  logic [fqd_pkg::TAG_WIDTH-1:0] next_tag,
   output logic [fqd_pkg::TAG_WIDTH-1:0] tag
);
   import fqd_pkg::*;

   logic [TAG_WIDTH-1:0] entry_ff;
   logic [TAG_WIDTH-1:0] entry_in;
   logic                 hit;

   assign hit      = live & ctl.match_en & (entry_ff == ctl.key);
   // removal point at or below this cell: take the neighbor's tag
   assign seed_out = seed_in | hit;
   assign tag      = entry_ff;

   always_comb begin
      if (load) begin
         entry_in = ctl.key;
      end else if (ctl.shift_en & seed_out) begin
         entry_in = next_tag;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[design/fifo_queue_with_delete_core.sv]
// top level of the fifo queue with delete by tag: controller and row of cells
//
//   channel  | ports                          | direction
//   request  | req_valid req_stall req_data   | in  (command, tag_in)
//   response | rsp_valid rsp_stall rsp_data   | out (status, tag_out, length)
//
// one item per cycle when not stalled: cells compare, shift or load in the same
// cycle as the item is taken; the result is in an output register next cycle.
// reset clears the count and the output valid; the cell contents are not reset.
// a stalled response holds the request side off until it is taken.
module fifo_queue_with_delete_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fqd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fqd_pkg::rsp_type rsp_data
);
   import fqd_pkg::*;

   logic [CNT_WIDTH-1:0] count_ff;
   logic [CNT_WIDTH-1:0] count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;

   logic                 accept;
   logic                 tag_null;
   logic                 is_empty;
   logic                 is_full;
   logic                 do_enqueue;
   logic                 do_dequeue;
   logic                 found;
   cell_ctl_type         ctl;

   logic [DEPTH-1:0]     live;
   logic [DEPTH-1:0]     load;
   logic [DEPTH:0]       seed;
   logic [TAG_WIDTH-1:0] cell_tag [DEPTH];

   assign accept   = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign tag_null = (req_data.tag_in == '0);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff >= CNT_WIDTH'(DEPTH));

   assign do_enqueue = accept & (req_data.command == CMD_ENQUEUE) & ~tag_null & ~is_full;
   assign do_dequeue = accept & (req_data.command == CMD_DEQUEUE) & ~is_empty;

   always_comb begin
      ctl.key      = req_data.tag_in;
      ctl.match_en = accept & (req_data.command == CMD_DELETE) & ~tag_null;
      ctl.shift_en = ctl.match_en | do_dequeue;
   end

   // dequeue removes cell zero, so it seeds the chain
   assign seed[0] = do_dequeue;
   assign found   = seed[DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         assign live[gi] = (CNT_WIDTH'(gi) < count_ff);
         assign load[gi] = do_enqueue & (CNT_WIDTH'(gi) == count_ff);

         if (gi == DEPTH - 1) begin : g_last
            fqd_cell u_cell (
               .clock    (clock),
               .ctl      (ctl),
               .live     (live[gi]),
               .load     (load[gi]),
               .seed_in  (seed[gi]),
               .seed_out (seed[gi+1]),
               .next_tag (cell_tag[gi]),
               .tag      (cell_tag[gi])
            );
         end else begin : g_mid
            fqd_cell u_cell (
               .clock    (clock),
               .ctl      (ctl),
               .live     (live[gi]),
               .load     (load[gi]),
               .seed_in  (seed[gi]),
               .seed_out (seed[gi+1]),
               .next_tag (cell_tag[gi+1]),
               .tag      (cell_tag[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      rsp_data_in.status  = ST_OK;
      rsp_data_in.tag_out = '0;
      count_in            = count_ff;
      case (req_data.command)
         CMD_ENQUEUE: begin
            if (tag_null) begin
               rsp_data_in.status = ST_NULL;
            end else if (is_full) begin
               rsp_data_in.status = ST_FULL;
            end else begin
               count_in = count_ff + CNT_WIDTH'(1);
            end
         end
         CMD_DEQUEUE: begin
            if (is_empty) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               rsp_data_in.tag_out = cell_tag[0];
               count_in            = count_ff - CNT_WIDTH'(1);
            end
         end
         CMD_DELETE: begin
            if (tag_null) begin
               rsp_data_in.status = ST_NULL;
            end else if (!found) begin
               rsp_data_in.status = ST_MISSING;
            end else begin
               count_in = count_ff - CNT_WIDTH'(1);
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.length = count_in;
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/fqd_checker.sv]
// port-level checks for the fifo queue with delete core, bound to the top level
module fqd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fqd_pkg::rsp_type rsp_data
);
   import fqd_pkg::*;

   // count never goes past the queue size
   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.length <= CNT_WIDTH'(DEPTH)))
      else $error("length beyond depth");

   // only a successful dequeue returns a tag
   a_tag_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.tag_out != '0) |-> (rsp_data.status == ST_OK))
      else $error("tag returned with error status");

   // an error leaves the count where the previous item left it
   a_error_keeps_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !req_stall && req_valid) |=>
         (rsp_data.status == ST_OK || rsp_data.length == $past(rsp_data.length)))
      else $error("failed item changed length");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled item changed");

endmodule

bind fifo_queue_with_delete_core fqd_checker u_fqd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
